[rtl/lkvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the keyed value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int AGE_W    = IDX_W;
    localparam int CNT_W    = IDX_W + 1;
    localparam int TAG_W    = 33;
    localparam int KEY_W    = 16;
    localparam int VAL_W    = 64;
    localparam int MODE_W   = 2;
    localparam int LIM_W    = 8;
    localparam int IN_W     = 104;
    localparam int OUT_W    = 80;

    localparam logic [MODE_W-1:0] MODE_PROBE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd2;

    typedef struct packed {
        logic             load;
        logic             scan_en;
        logic             decide;
        logic             upd_en;
        logic             finish;
        logic [IDX_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_sts;

endpackage

[rtl/lru_keyed_value_cache.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_value_cache
// fully associative lru cache of 64-bit values keyed by a two-part key
// ----------------------------------------------------------------------------
// operation: a tag scan pass, a decision, then an age update pass, each pass
//   covering every entry, one entry per cycle of the memory ports
// a new request is taken only after the last one has finished; a request is taken while a result waits
// reset: synchronous active low, clears valid bits, occupancy, limit to 128
module lru_keyed_value_cache (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lkvc_pkg::LIM_W-1:0]   i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // mode[1:0], key_high[17:2], key_low[33:18], value_in[97:34], zero pad
    input  logic [lkvc_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // hit[0], value_out[64:1], evicted[65], occupancy[73:66], zero pad
    output logic [lkvc_pkg::OUT_W-1:0]   m_axis_tdata
);
    import lkvc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lkvc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (s_axis_tdata),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .o_rsp       (m_axis_tdata)
    );

endmodule

[rtl/lkvc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// sequencer: tag scan pass, decision, recency update pass, result
// ----------------------------------------------------------------------------
module lkvc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  lkvc_pkg::t_sts i_sts,
    output lkvc_pkg::t_cmd o_cmd
);
    import lkvc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_SDRAIN = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_UPD    = 7'b0010000,
        S_UDRAIN = 7'b0100000,
        S_FIN    = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic             w_last;

    assign w_last      = (r_addr == IDX_W'(CAPACITY - 1));
    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        o_cmd   = '0;
        o_cmd.addr = r_addr;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_addr     = '0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                n_addr        = r_addr + 1'b1;
                if (w_last) n_state = S_SDRAIN;
            end
            S_SDRAIN: n_state = S_DECIDE;
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_addr       = '0;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_en = 1'b1;
                n_addr       = r_addr + 1'b1;
                if (w_last) n_state = S_UDRAIN;
            end
            S_UDRAIN: n_state = S_FIN;
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

endmodule

[rtl/lkvc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_dp
// tag, value and age memories, valid bits, scan and update datapath
// ----------------------------------------------------------------------------
module lkvc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkvc_pkg::t_cmd               i_cmd,
    output lkvc_pkg::t_sts               o_sts,
    input  logic                         i_cfg_we,
    input  logic [lkvc_pkg::LIM_W-1:0]   i_cfg_wdata,
    input  logic [lkvc_pkg::IN_W-1:0]    i_req,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output logic [lkvc_pkg::OUT_W-1:0]   o_rsp
);
    import lkvc_pkg::*;

    logic [TAG_W-1:0] r_tag_mem [CAPACITY];
    logic [VAL_W-1:0] r_val_mem [CAPACITY];
    logic [AGE_W-1:0] r_age_mem [CAPACITY];
    logic [CAPACITY-1:0] r_valid;

    logic [LIM_W-1:0] r_limit;
    logic [CNT_W-1:0] r_count;

    logic [MODE_W-1:0] r_mode;
    logic [TAG_W-1:0]  r_tag;
    logic [VAL_W-1:0]  r_val;

    logic [TAG_W-1:0] r_tag_rd;
    logic [AGE_W-1:0] r_age_rd;
    logic [VAL_W-1:0] r_val_rd;
    logic             r_scan_vld, r_upd_vld;
    logic [IDX_W-1:0] r_pipe_idx;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [AGE_W-1:0] r_hit_age;
    logic             r_old_fnd;
    logic [IDX_W-1:0] r_old_idx;
    logic [AGE_W-1:0] r_old_age;
    logic             r_free_fnd;
    logic [IDX_W-1:0] r_free_idx;

    logic             r_upd_on;
    logic [IDX_W-1:0] r_target;
    logic [CNT_W-1:0] r_thr;
    logic             r_evict;

    logic             r_out_vld;
    logic [OUT_W-1:0] r_out;

    logic [KEY_W:0]   w_kh1;
    logic [TAG_W-1:0] w_tag;
    logic [CNT_W-1:0] w_lim;
    logic             w_full;
    logic             w_pv;

    assign w_kh1 = {1'b0, i_req[MODE_W +: KEY_W]} + (KEY_W+1)'(1);
    assign w_tag = {w_kh1, {KEY_W{1'b0}}} + TAG_W'(i_req[MODE_W+KEY_W +: KEY_W]);
    assign w_lim = (r_limit == '0) ? CNT_W'(1) :
                   ({1'b0, r_limit} > (LIM_W+1)'(CAPACITY)) ? CNT_W'(CAPACITY) :
                   CNT_W'(r_limit);
    assign w_full = (r_count >= w_lim);
    assign w_pv   = r_valid[r_pipe_idx];

    assign o_sts.out_busy = r_out_vld && !i_rsp_ready;
    assign o_rsp_valid    = r_out_vld;
    assign o_rsp          = r_out;

    // configuration and request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_W'(CAPACITY);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
        if (i_cmd.load) begin
            r_mode <= i_req[MODE_W-1:0];
            r_tag  <= w_tag;
            r_val  <= i_req[MODE_W+2*KEY_W +: VAL_W];
        end
    end

    // memory reads
    always_ff @(posedge i_clk) begin
        r_tag_rd <= r_tag_mem[i_cmd.addr];
        r_age_rd <= r_age_mem[i_cmd.addr];
        if (i_cmd.decide) r_val_rd <= r_val_mem[r_hit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
            r_upd_vld  <= 1'b0;
        end else begin
            r_scan_vld <= i_cmd.scan_en;
            r_upd_vld  <= i_cmd.upd_en;
        end
        r_pipe_idx <= i_cmd.addr;
    end

    // scan pass: match, oldest valid, first free
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit      <= 1'b0;
            r_old_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
            r_hit_idx  <= '0;
            r_hit_age  <= '0;
            r_old_idx  <= '0;
            r_old_age  <= '0;
            r_free_idx <= '0;
        end else if (r_scan_vld) begin
            if (w_pv && r_tag_rd == r_tag) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_pipe_idx;
                r_hit_age <= r_age_rd;
            end
            if (w_pv && (!r_old_fnd || r_age_rd > r_old_age)) begin
                r_old_fnd <= 1'b1;
                r_old_idx <= r_pipe_idx;
                r_old_age <= r_age_rd;
            end
            if (!w_pv && !r_free_fnd) begin
                r_free_fnd <= 1'b1;
                r_free_idx <= r_pipe_idx;
            end
        end
    end

    // decision, writes and recency update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_count  <= '0;
            r_upd_on <= 1'b0;
            r_evict  <= 1'b0;
        end else if (i_cmd.decide) begin
            r_upd_on <= 1'b0;
            r_evict  <= 1'b0;
            if (r_hit && (r_mode == MODE_GET || r_mode == MODE_PUT)) begin
                r_upd_on <= 1'b1;
                r_target <= r_hit_idx;
                r_thr    <= CNT_W'(r_hit_age);
            end else if (r_mode == MODE_PUT) begin
                r_upd_on <= 1'b1;
                r_thr    <= CNT_W'(CAPACITY);
                if (w_full) begin
                    r_evict  <= 1'b1;
                    r_target <= r_old_idx;
                    r_valid[r_old_idx] <= 1'b1;
                end else begin
                    r_target <= r_free_idx;
                    r_valid[r_free_idx] <= 1'b1;
                    r_count  <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && r_mode == MODE_PUT) begin
            if (r_hit) begin
                r_val_mem[r_hit_idx] <= r_val;
            end else if (w_full) begin
                r_val_mem[r_old_idx] <= r_val;
                r_tag_mem[r_old_idx] <= r_tag;
            end else begin
                r_val_mem[r_free_idx] <= r_val;
                r_tag_mem[r_free_idx] <= r_tag;
            end
        end
        if (r_upd_vld && r_upd_on) begin
            if (r_pipe_idx == r_target) begin
                r_age_mem[r_pipe_idx] <= '0;
            end else if (w_pv && CNT_W'(r_age_rd) < r_thr) begin
                r_age_mem[r_pipe_idx] <= r_age_rd + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out <= {6'b0, LIM_W'(r_count), r_evict,
                      (r_hit && r_mode == MODE_GET) ? r_val_rd : VAL_W'(0), r_hit};
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// regression bench for the lru keyed value cache: directed and random
// probe/get/put/spare requests under several occupancy limits, random idling on
// both stream sides, results checked against an in-bench lru predictor
// ----------------------------------------------------------------------------

class cache_scoreboard;
    bit          ent_valid [lkvc_pkg::CAPACITY];
    bit [32:0]   ent_tag   [lkvc_pkg::CAPACITY];
    bit [63:0]   ent_value [lkvc_pkg::CAPACITY];
    int unsigned ent_age   [lkvc_pkg::CAPACITY];
    int unsigned fill;
    bit [7:0]    limit_reg;
    bit [73:0]   pending [$];
    int          errors;
    int          checked;
    int          hits;
    int          evictions;

    function void clear();
        foreach (ent_valid[i]) ent_valid[i] = 0;
        fill = 0;
        limit_reg = 8'd128;
    endfunction

    function int lookup(bit [32:0] tag);
        foreach (ent_valid[i])
            if (ent_valid[i] && ent_tag[i] == tag) return i;
        return -1;
    endfunction

    function void promote(int idx);
        int unsigned a;
        a = ent_age[idx];
        foreach (ent_valid[i])
            if (ent_valid[i] && ent_age[i] < a) ent_age[i]++;
        ent_age[idx] = 0;
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(bit [1:0] mode, bit [15:0] kh, bit [15:0] kl, bit [63:0] val);
        bit [32:0]   tag;
        int          idx;
        int          slot;
        int          oldest;
        int unsigned lim;
        bit [63:0]   vout;
        bit          ev;
        tag  = ({17'd0, kh} + 33'd1 << 16) + {17'd0, kl};
        idx  = lookup(tag);
        vout = '0;
        ev   = 0;
        slot = -1;
        if (mode == lkvc_pkg::MODE_GET) begin
            if (idx >= 0) begin
                vout = ent_value[idx];
                promote(idx);
            end
        end else if (mode == lkvc_pkg::MODE_PUT) begin
            if (idx >= 0) begin
                ent_value[idx] = val;
                promote(idx);
            end else begin
                lim = (limit_reg == 0) ? 1 : (limit_reg > lkvc_pkg::CAPACITY)
                      ? lkvc_pkg::CAPACITY : limit_reg;
                if (fill >= lim) begin
                    oldest = -1;
                    foreach (ent_valid[i])
                        if (ent_valid[i] && (oldest < 0 || ent_age[i] > ent_age[oldest]))
                            oldest = i;
                    if (oldest >= 0) begin
                        ent_valid[oldest] = 0;
                        fill--;
                        slot = oldest;
                        ev = 1;
                    end
                end
                if (slot < 0)
                    foreach (ent_valid[i])
                        if (!ent_valid[i] && slot < 0) slot = i;
                if (slot >= 0) begin
                    foreach (ent_valid[i])
                        if (ent_valid[i]) ent_age[i]++;
                    ent_valid[slot] = 1;
                    ent_tag[slot]   = tag;
                    ent_value[slot] = val;
                    ent_age[slot]   = 0;
                    fill++;
                end
            end
        end
        pending.push_back({fill[7:0], ev, vout, idx >= 0});
    endfunction

    function void report(string what, logic [79:0] got, bit [73:0] exp);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got[73:0], exp);
    endfunction

    function void check_result(logic [79:0] got);
        bit [73:0] exp;
        if (pending.size() == 0) begin
            report("unexpected result", got, '0);
            return;
        end
        exp = pending.pop_front();
        checked++;
        if (exp[0]) hits++;
        if (exp[65]) evictions++;
        if (got[0] !== exp[0]) report("hit", got, exp);
        if (got[64:1] !== exp[64:1]) report("value_out", got, exp);
        if (got[65] !== exp[65]) report("evicted", got, exp);
        if (got[73:66] !== exp[73:66]) report("occupancy", got, exp);
    endfunction
endclass

module tb_top;
    import lkvc_pkg::*;

    localparam int LATENCY   = 261;
    localparam int WDOG_MAX  = 20000;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [LIM_W-1:0]   i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;

    cache_scoreboard sb;
    int  idle_cycles = 0;
    bit  hold_sink;
    int  requests;
    bit [15:0] key_pool [8];

    lru_keyed_value_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // result side: random stalls, one long hold-off when asked
    initial begin
        int g;
        m_axis_tready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge i_clk);
                hold_sink = 0;
            end
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("watchdog expired");
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_request(bit [1:0] mode, bit [15:0] kh, bit [15:0] kl, bit [63:0] val);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {6'd0, val, kl, kh, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(mode, kh, kl, val);
        requests++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_limit(bit [7:0] lim);
        i_cfg_we    <= 1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we    <= 0;
        sb.limit_reg = lim;
    endtask

    task automatic random_phase(int n);
        bit [1:0]  mode;
        bit [15:0] kh;
        bit [15:0] kl;
        int        r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            // mostly a small key set so hits, touches and evictions happen
            if (r < 85) begin
                kh = key_pool[$urandom_range(0, 7)];
                kl = $urandom_range(0, 5);
            end else begin
                kh = $urandom;
                kl = $urandom;
            end
            r = $urandom_range(0, 99);
            mode = (r < 20) ? MODE_PROBE : (r < 50) ? MODE_GET :
                   (r < 95) ? MODE_PUT : MODE_SPARE;
            send_request(mode, kh, kl, {$urandom, $urandom});
        end
    endtask

    initial begin
        bit [7:0] limits [6] = '{8'd0, 8'd1, 8'd2, 8'd7, 8'd200, 8'd128};
        sb = new();
        sb.clear();
        requests      = 0;
        hold_sink     = 0;
        i_rst_n       = 0;
        i_cfg_we      = 0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 16'hFFFF;
        key_pool[1] = 16'h0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: key extremes, every mode, miss on get, overwrite, keys with adjacent tags
        send_request(MODE_GET,   16'h0000, 16'h0000, 64'h0);
        send_request(MODE_PUT,   16'h0000, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(MODE_PUT,   16'hFFFF, 16'hFFFF, 64'h0);
        send_request(MODE_PROBE, 16'hFFFF, 16'hFFFF, 64'hDEAD);
        send_request(MODE_GET,   16'h0000, 16'h0000, 64'h0);
        send_request(MODE_PUT,   16'h0000, 16'h0000, 64'h0123_4567_89AB_CDEF);
        send_request(MODE_GET,   16'h0000, 16'h0000, 64'h0);
        send_request(MODE_SPARE, 16'h0000, 16'h0000, 64'h0);
        send_request(MODE_PUT,   16'h0001, 16'h0000, 64'h5555_5555_5555_5555);
        send_request(MODE_PUT,   16'h0000, 16'hFFFF, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(MODE_GET,   16'h0001, 16'h0000, 64'h0);
        send_request(MODE_GET,   16'h0000, 16'hFFFF, 64'h0);
        drain();

        // lower the limit below occupancy, then evict repeatedly
        set_limit(8'd2);
        send_request(MODE_PUT, 16'h1234, 16'h0001, 64'h1);
        send_request(MODE_PUT, 16'h1234, 16'h0002, 64'h2);
        send_request(MODE_GET, 16'h1234, 16'h0001, 64'h0);
        send_request(MODE_PUT, 16'h1234, 16'h0003, 64'h3);
        send_request(MODE_PROBE, 16'h1234, 16'h0002, 64'h0);
        drain();

        // long receiver hold-off while requests keep coming
        hold_sink = 1;
        random_phase(20);
        drain();

        foreach (limits[i]) begin
            set_limit(limits[i]);
            random_phase(i == 5 ? 760 : 200);
            drain();
        end

        $display("covered %0d requests, %0d results, %0d hits, %0d evictions",
                 requests, sb.checked, sb.hits, sb.evictions);
        $display("limits 0, 1, 2, 7, 200 and 128 with a long result stall");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
